@@ src/ial_pkg.sv @@
// Package for the indexed array list: command, status, state and cell op codes.
// Also holds fixed port widths and parameter defaults; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ial_pkg;

  localparam int DEPTH_DEF     = 256;
  localparam int WORD_BITS_DEF = 32;
  localparam int CMD_W         = 3;
  localparam int IDX_W         = 9;
  localparam int STAT_W        = 3;
  localparam int POS_W         = 8;
  localparam int CNT_OUT_W     = 9;
  localparam int CAP_W         = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_READ   = 3'd2,
    CMD_WRITE  = 3'd3,
    CMD_SEARCH = 3'd4,
    CMD_SORTED = 3'd5
  } ial_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_UNSORTED  = 3'd4
  } ial_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } ial_state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SH_LOAD,
    OP_SH_SHIFT,
    OP_INS,
    OP_DEL,
    OP_WR
  } ial_cell_op_t;

endpackage
`default_nettype wire

@@ src/ial_cell.sv @@
// One list cell: an element word plus a shadow word that scans toward the head.
// Depends on ial_pkg for the cell op codes.
`timescale 1ns / 1ps
`default_nettype none
module ial_cell
  import ial_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int XW        = IDX_W,
  parameter int CELL_IDX  = 0
) (
  input  wire logic                 clk,
  input  wire ial_cell_op_t         op,
  input  wire logic [XW-1:0]        op_idx,
  input  wire logic [WORD_BITS-1:0] op_val,
  input  wire logic [WORD_BITS-1:0] word_lo,
  input  wire logic [WORD_BITS-1:0] word_hi,
  input  wire logic [WORD_BITS-1:0] shadow_hi,
  output logic      [WORD_BITS-1:0] word,
  output logic      [WORD_BITS-1:0] shadow
);

  localparam logic [XW-1:0] MY_IDX = XW'(CELL_IDX);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;
  logic [WORD_BITS-1:0] shadow_r;
  logic [WORD_BITS-1:0] shadow_nxt;

  always_comb begin
    word_nxt   = word_r;
    shadow_nxt = shadow_r;
    case (op)
      OP_SH_LOAD:  shadow_nxt = word_r;
      OP_SH_SHIFT: shadow_nxt = shadow_hi;
      OP_INS: begin
        if (MY_IDX > op_idx) begin
          word_nxt = word_lo;
        end else if (MY_IDX == op_idx) begin
          word_nxt = op_val;
        end
      end
      OP_DEL: begin
        if (MY_IDX >= op_idx) begin
          word_nxt = word_hi;
        end
      end
      OP_WR: begin
        if (MY_IDX == op_idx) begin
          word_nxt = op_val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r   <= word_nxt;
    shadow_r <= shadow_nxt;
  end

  assign word   = word_r;
  assign shadow = shadow_r;

endmodule
`default_nettype wire

@@ src/ial_chain.sv @@
// Row of DEPTH list cells linked to their neighbors; shadow of cell 0 is the scan head.
// Depends on ial_pkg and ial_cell.
`timescale 1ns / 1ps
`default_nettype none
module ial_chain
  import ial_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int XW        = IDX_W
) (
  input  wire logic                 clk,
  input  wire ial_cell_op_t         op,
  input  wire logic [XW-1:0]        op_idx,
  input  wire logic [WORD_BITS-1:0] op_val,
  output logic      [WORD_BITS-1:0] head
);

  logic [WORD_BITS-1:0] word_w   [DEPTH];
  logic [WORD_BITS-1:0] shadow_w [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] lo_w;
    logic [WORD_BITS-1:0] hi_w;
    logic [WORD_BITS-1:0] sh_hi_w;

    if (i == 0) begin : g_first
      assign lo_w = '0;
    end else begin : g_mid_lo
      assign lo_w = word_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign hi_w    = '0;
      assign sh_hi_w = '0;
    end else begin : g_mid_hi
      assign hi_w    = word_w[i+1];
      assign sh_hi_w = shadow_w[i+1];
    end

    ial_cell #(
      .WORD_BITS (WORD_BITS),
      .XW        (XW),
      .CELL_IDX  (i)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .op_idx    (op_idx),
      .op_val    (op_val),
      .word_lo   (lo_w),
      .word_hi   (hi_w),
      .shadow_hi (sh_hi_w),
      .word      (word_w[i]),
      .shadow    (shadow_w[i])
    );
  end

  assign head = shadow_w[0];

endmodule
`default_nettype wire

@@ src/ial_ctrl.sv @@
// Command sequencer: accepts commands, scans the chain head, applies the update.
// Holds count, capacity and result registers. Depends on ial_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ial_ctrl
  import ial_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int XW        = IDX_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [CMD_W-1:0]     in_cmd,
  input  wire logic [IDX_W-1:0]     in_index,
  input  wire logic [WORD_BITS-1:0] in_value,
  output logic                      out_valid,
  output logic [STAT_W-1:0]         out_status,
  output logic [WORD_BITS-1:0]      out_data,
  output logic [POS_W-1:0]          out_position,
  output logic [CNT_OUT_W-1:0]      out_count,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CAP_W-1:0]     cfg_data,
  output ial_cell_op_t              cell_op,
  output logic [XW-1:0]             cell_idx,
  output logic [WORD_BITS-1:0]      cell_val,
  input  wire logic [WORD_BITS-1:0] head
);

  localparam int CW = $clog2(DEPTH + 1);

  ial_state_t           state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [XW-1:0]        idx_r, idx_nxt;
  logic [WORD_BITS-1:0] val_r, val_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CAP_W-1:0]     cap_r, cap_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [CW-1:0]        len_r, len_nxt;
  logic                 hit_r, hit_nxt;
  logic [CW-1:0]        hit_pos_r, hit_pos_nxt;
  logic                 gt_r, gt_nxt;
  logic [CW-1:0]        gt_pos_r, gt_pos_nxt;
  logic                 bad_r, bad_nxt;
  logic [WORD_BITS-1:0] prev_r, prev_nxt;
  logic [WORD_BITS-1:0] data_r, data_nxt;

  logic                 ov_r, ov_nxt;
  ial_status_t          ost_r, ost_nxt;
  logic [WORD_BITS-1:0] odata_r, odata_nxt;
  logic [POS_W-1:0]     opos_r, opos_nxt;
  logic [CNT_OUT_W-1:0] ocnt_r, ocnt_nxt;

  logic [XW-1:0] n_x;
  logic [XW-1:0] lim_x;
  logic [XW-1:0] in_idx_x;
  logic [CW-1:0] ins_at;

  assign n_x      = XW'(cnt_r);
  assign lim_x    = (XW'(cap_r) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(cap_r);
  assign in_idx_x = XW'(in_index);
  assign ins_at   = gt_r ? gt_pos_r : cnt_r;

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    idx_nxt     = idx_r;
    val_nxt     = val_r;
    cnt_nxt     = cnt_r;
    cap_nxt     = cap_r;
    k_nxt       = k_r;
    len_nxt     = len_r;
    hit_nxt     = hit_r;
    hit_pos_nxt = hit_pos_r;
    gt_nxt      = gt_r;
    gt_pos_nxt  = gt_pos_r;
    bad_nxt     = bad_r;
    prev_nxt    = prev_r;
    data_nxt    = data_r;
    ov_nxt      = 1'b0;
    ost_nxt     = ost_r;
    odata_nxt   = odata_r;
    opos_nxt    = opos_r;
    ocnt_nxt    = ocnt_r;
    cell_op     = OP_HOLD;
    cell_idx    = idx_r;

    if (cfg_valid) begin
      cap_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_cmd;
          idx_nxt = in_idx_x;
          val_nxt = in_value;
          k_nxt   = '0;
          hit_nxt = 1'b0;
          gt_nxt  = 1'b0;
          bad_nxt = 1'b0;
          cell_op = OP_SH_LOAD;
          case (in_cmd)
            CMD_SEARCH, CMD_SORTED: len_nxt = cnt_r;
            CMD_READ, CMD_DELETE: begin
              len_nxt = (in_idx_x < n_x) ? CW'(in_idx_x + 1'b1) : '0;
            end
            default: len_nxt = '0;
          endcase
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (k_r == len_r) begin
          state_nxt = S_APPLY;
        end else begin
          if (cmd_r == CMD_SEARCH && !hit_r && head == val_r) begin
            hit_nxt     = 1'b1;
            hit_pos_nxt = k_r;
          end
          if (cmd_r == CMD_SORTED) begin
            if (k_r != '0 && $signed(head) <= $signed(prev_r)) begin
              bad_nxt = 1'b1;
            end
            if (!gt_r && $signed(head) > $signed(val_r)) begin
              gt_nxt     = 1'b1;
              gt_pos_nxt = k_r;
            end
          end
          if (XW'(k_r) == idx_r) begin
            data_nxt = head;
          end
          prev_nxt = head;
          cell_op  = OP_SH_SHIFT;
          k_nxt    = k_r + 1'b1;
        end
      end

      S_APPLY: begin
        ost_nxt   = ST_OK;
        odata_nxt = '0;
        opos_nxt  = '0;
        case (cmd_r)
          CMD_INSERT: begin
            if (idx_r > n_x) begin
              ost_nxt = ST_RANGE;
            end else if (n_x >= lim_x) begin
              ost_nxt = ST_FULL;
            end else begin
              cell_op = OP_INS;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          CMD_DELETE: begin
            if (idx_r >= n_x) begin
              ost_nxt = ST_RANGE;
            end else begin
              odata_nxt = data_r;
              cell_op   = OP_DEL;
              cnt_nxt   = cnt_r - 1'b1;
            end
          end
          CMD_READ: begin
            if (idx_r >= n_x) begin
              ost_nxt = ST_RANGE;
            end else begin
              odata_nxt = data_r;
            end
          end
          CMD_WRITE: begin
            if (idx_r >= n_x) begin
              ost_nxt = ST_RANGE;
            end else begin
              cell_op = OP_WR;
            end
          end
          CMD_SEARCH: begin
            if (hit_r) begin
              opos_nxt = POS_W'(hit_pos_r);
            end else begin
              ost_nxt = ST_NOT_FOUND;
            end
          end
          CMD_SORTED: begin
            if (bad_r) begin
              ost_nxt = ST_UNSORTED;
            end else if (n_x >= lim_x) begin
              ost_nxt = ST_FULL;
            end else begin
              cell_op  = OP_INS;
              cell_idx = XW'(ins_at);
              opos_nxt = POS_W'(ins_at);
              cnt_nxt  = cnt_r + 1'b1;
            end
          end
          default: ;
        endcase
        ocnt_nxt  = CNT_OUT_W'(cnt_nxt);
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      cap_r   <= CAP_RESET;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cap_r   <= cap_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    idx_r     <= idx_nxt;
    val_r     <= val_nxt;
    k_r       <= k_nxt;
    len_r     <= len_nxt;
    hit_r     <= hit_nxt;
    hit_pos_r <= hit_pos_nxt;
    gt_r      <= gt_nxt;
    gt_pos_r  <= gt_pos_nxt;
    bad_r     <= bad_nxt;
    prev_r    <= prev_nxt;
    data_r    <= data_nxt;
    ost_r     <= ost_nxt;
    odata_r   <= odata_nxt;
    opos_r    <= opos_nxt;
    ocnt_r    <= ocnt_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign cell_val     = val_r;
  assign out_valid    = ov_r;
  assign out_status   = ost_r;
  assign out_data     = odata_r;
  assign out_position = opos_r;
  assign out_count    = ocnt_r;

  a_strobe_after_apply : assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> $past(state_r == S_APPLY))
    else $error("result strobe without a completed command");

  a_strobe_single : assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !$past(ov_r))
    else $error("result strobe held for two cycles");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    XW'(cnt_r) <= XW'(DEPTH))
    else $error("element count above store depth");

  a_scan_bound : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> k_r <= len_r)
    else $error("scan ran past its length");

  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_APPLY |=> $stable(cnt_r))
    else $error("count changed outside the apply cycle");

endmodule
`default_nettype wire

@@ src/indexed_array_list_top.sv @@
// Indexed array list top: sequencer plus a row of list cells.
// A start transfer enters the scan, which reads no elements for insert, write and unused
// codes, index+1 for a valid read or delete, and count for search and sorted insert; the
// apply state then registers the result strobe. busy drops with the strobe cycle, so the
// next transfer may start in it. The receiver cannot stall; results are not held.
// Synchronous active-low reset clears count to zero and capacity to 256; words stay unknown.
`timescale 1ns / 1ps
`default_nettype none
module indexed_array_list_top
  import ial_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [CMD_W-1:0]     in_cmd,
  input  wire logic [IDX_W-1:0]     in_index,
  input  wire logic [WORD_BITS-1:0] in_value,
  output logic                      out_valid,
  output logic [STAT_W-1:0]         out_status,
  output logic [WORD_BITS-1:0]      out_data,
  output logic [POS_W-1:0]          out_position,
  output logic [CNT_OUT_W-1:0]      out_count,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CAP_W-1:0]     cfg_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  ial_cell_op_t         cell_op;
  logic [XW-1:0]        cell_idx;
  logic [WORD_BITS-1:0] cell_val;
  logic [WORD_BITS-1:0] head;

  ial_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .XW        (XW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_index     (in_index),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_data     (out_data),
    .out_position (out_position),
    .out_count    (out_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .cell_op      (cell_op),
    .cell_idx     (cell_idx),
    .cell_val     (cell_val),
    .head         (head)
  );

  ial_chain #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .XW        (XW)
  ) u_chain (
    .clk    (clk),
    .op     (cell_op),
    .op_idx (cell_idx),
    .op_val (cell_val),
    .head   (head)
  );

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for indexed_array_list_top: commands go in over start/busy,
// and every strobed result is checked against an in-bench list predictor.
// Depends on ial_pkg and the indexed_array_list_top RTL only.
`timescale 1ns / 1ps
module tb_top;
  import ial_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  localparam int WORD_W = WORD_BITS_DEF;
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_ITEMS = 1100;

  typedef struct {
    logic [CMD_W-1:0]     cmd;
    logic [IDX_W-1:0]     index;
    logic [STAT_W-1:0]    status;
    logic [WORD_W-1:0]    data;
    logic [POS_W-1:0]     position;
    logic [CNT_OUT_W-1:0] count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [CMD_W-1:0] in_cmd = '0;
  logic [IDX_W-1:0] in_index = '0;
  logic [WORD_W-1:0] in_value = '0;
  logic cfg_valid = 1'b0;
  logic [CAP_W-1:0] cfg_data = '0;
  logic busy;
  logic out_valid;
  logic [STAT_W-1:0] out_status;
  logic [WORD_W-1:0] out_data;
  logic [POS_W-1:0] out_position;
  logic [CNT_OUT_W-1:0] out_count;
  logic cfg_ready;

  logic signed [WORD_W-1:0] shadow_words [LIST_DEPTH];
  int unsigned shadow_len = 0;
  int unsigned shadow_cap = CAP_RESET;
  list_result_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned longest_list = 0;
  int unsigned cap_writes = 0;
  int unsigned idle_pct = 18;
  int unsigned cmd_tally [8];
  int unsigned status_tally [8];

  indexed_array_list_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_index     (in_index),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_data     (out_data),
    .out_position (out_position),
    .out_count    (out_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic list_result_t apply_list_cmd(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                                  logic signed [WORD_W-1:0] val);
    list_result_t r;
    int unsigned n;
    int unsigned lim;
    int unsigned i;
    bit ascending;
    n = shadow_len;
    lim = (shadow_cap > LIST_DEPTH) ? LIST_DEPTH : shadow_cap;
    r.cmd = cmd;
    r.index = idx;
    r.status = ST_OK;
    r.data = '0;
    r.position = '0;
    ascending = 1'b1;
    case (cmd)
      CMD_INSERT: begin
        if (idx > n) begin
          r.status = ST_RANGE;
        end else if (n >= lim) begin
          r.status = ST_FULL;
        end else begin
          for (i = n; i > idx; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[idx] = val;
          shadow_len = n + 1;
        end
      end
      CMD_DELETE: begin
        if (idx >= n) begin
          r.status = ST_RANGE;
        end else begin
          r.data = shadow_words[idx];
          for (i = idx; i + 1 < n; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len = n - 1;
        end
      end
      CMD_READ: begin
        if (idx >= n) r.status = ST_RANGE;
        else r.data = shadow_words[idx];
      end
      CMD_WRITE: begin
        if (idx >= n) r.status = ST_RANGE;
        else shadow_words[idx] = val;
      end
      CMD_SEARCH: begin
        r.status = ST_NOT_FOUND;
        for (i = 0; i < n; i++) begin
          if (shadow_words[i] == val) begin
            r.status = ST_OK;
            r.position = i[POS_W-1:0];
            break;
          end
        end
      end
      CMD_SORTED: begin
        for (i = 1; i < n; i++) begin
          if (shadow_words[i] <= shadow_words[i-1]) ascending = 1'b0;
        end
        if (!ascending) begin
          r.status = ST_UNSORTED;
        end else if (n >= lim) begin
          r.status = ST_FULL;
        end else begin
          i = n;
          while (i > 0 && shadow_words[i-1] > val) begin
            shadow_words[i] = shadow_words[i-1];
            i--;
          end
          shadow_words[i] = val;
          r.position = i[POS_W-1:0];
          shadow_len = n + 1;
        end
      end
      default: ;
    endcase
    r.count = shadow_len[CNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic void report_failure(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, msg);
  endfunction

  function automatic int unsigned last_index();
    return (shadow_len > 0) ? shadow_len - 1 : 0;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(int unsigned hi);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 78) return IDX_W'($urandom_range(0, hi));
    if (roll < 96) return IDX_W'($urandom_range(0, 511));
    return 9'h100;
  endfunction

  function automatic logic [WORD_W-1:0] pick_value(int unsigned spread);
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return '0;
          default: return '1;
        endcase
      end
      2, 3: begin
        if (shadow_len > 0) return shadow_words[$urandom_range(0, shadow_len - 1)];
      end
      default: ;
    endcase
    return $urandom_range(0, 2 * spread) - spread;
  endfunction

  // Enter at a falling edge; leave at a falling edge with start still high.
  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                          logic [WORD_W-1:0] val);
    list_result_t r;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_index <= idx;
    in_value <= val;
    do @(posedge clk); while (busy);
    r = apply_list_cmd(cmd, idx, val);
    pending_results.push_back(r);
    items_sent++;
    cmd_tally[cmd]++;
    status_tally[r.status]++;
    if (shadow_len > longest_list) longest_list = shadow_len;
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    cfg_data <= cap;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    shadow_cap = cap;
    cap_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic trim_list(int unsigned keep);
    while (shadow_len > keep)
      send_cmd(CMD_DELETE, IDX_W'($urandom_range(0, shadow_len - 1)), pick_value(20));
  endtask

  task automatic random_mixed_item();
    logic [CMD_W-1:0] c;
    int unsigned roll;
    int unsigned hi;
    roll = $urandom_range(99);
    if (roll < 28) c = CMD_INSERT;
    else if (roll < 50) c = CMD_DELETE;
    else if (roll < 64) c = CMD_READ;
    else if (roll < 74) c = CMD_WRITE;
    else if (roll < 86) c = CMD_SEARCH;
    else if (roll < 97) c = CMD_SORTED;
    else c = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
    hi = (c == CMD_INSERT) ? shadow_len : last_index();
    send_cmd(c, pick_index(hi), pick_value(20));
  endtask

  task automatic sorted_session(int unsigned items);
    int unsigned roll;
    trim_list(0);
    repeat (items) begin
      roll = $urandom_range(99);
      if (roll < 55) send_cmd(CMD_SORTED, pick_index(shadow_len), pick_value(5000));
      else if (roll < 72) send_cmd(CMD_SEARCH, pick_index(shadow_len), pick_value(5000));
      else if (roll < 84) send_cmd(CMD_READ, pick_index(last_index()), pick_value(5000));
      else if (roll < 95) send_cmd(CMD_DELETE, pick_index(last_index()), pick_value(5000));
      else send_cmd(CMD_WRITE, pick_index(last_index()), pick_value(5000));
    end
  endtask

  task automatic test_directed_basics();
    send_cmd(CMD_READ, 9'd0, 32'd0);
    send_cmd(CMD_DELETE, 9'd0, 32'd0);
    send_cmd(CMD_WRITE, 9'd0, 32'h1234_5678);
    send_cmd(CMD_SEARCH, 9'd0, 32'd0);
    send_cmd(CMD_INSERT, 9'd1, 32'd9);
    send_cmd(CMD_SORTED, 9'h1FF, 32'd7);
    send_cmd(CMD_INSERT, 9'd0, 32'h8000_0000);
    send_cmd(CMD_INSERT, 9'd2, 32'h7FFF_FFFF);
    send_cmd(CMD_SORTED, 9'd0, 32'hFFFF_FFFF);
    send_cmd(CMD_SORTED, 9'd0, 32'd7);
    send_cmd(CMD_SORTED, 9'd0, 32'd0);
    send_cmd(CMD_SEARCH, 9'd0, 32'd7);
    send_cmd(CMD_SEARCH, 9'd0, 32'hFFFF_FFFF);
    send_cmd(CMD_SEARCH, 9'd0, 32'h5555_AAAA);
    send_cmd(CMD_READ, 9'd4, 32'd0);
    send_cmd(CMD_READ, 9'd5, 32'd0);
    send_cmd(CMD_READ, 9'h1FF, 32'd0);
    send_cmd(CMD_WRITE, 9'd3, 32'hA5A5_5A5A);
    send_cmd(CMD_READ, 9'd3, 32'd0);
    send_cmd(CMD_DELETE, 9'd0, 32'd0);
    send_cmd(CMD_DELETE, 9'd3, 32'd0);
    send_cmd(CMD_DELETE, 9'h100, 32'd0);
    send_cmd(CMD_SPARE_A, 9'd1, 32'hFFFF_FFFF);
    send_cmd(CMD_SPARE_B, 9'h1FF, 32'h0F0F_F0F0);
  endtask

  task automatic test_capacity_limits();
    drain_results();
    write_capacity(9'd3);
    send_cmd(CMD_INSERT, 9'd0, 32'd1);
    send_cmd(CMD_INSERT, 9'd5, 32'd1);
    send_cmd(CMD_SORTED, 9'd0, 32'd1);
    send_cmd(CMD_DELETE, 9'd2, 32'd0);
    send_cmd(CMD_SORTED, 9'd0, 32'd100);
    send_cmd(CMD_SORTED, 9'd0, 32'd50);
    drain_results();
    write_capacity(9'd0);
    send_cmd(CMD_INSERT, 9'd0, 32'd2);
    trim_list(0);
    send_cmd(CMD_SORTED, 9'd0, 32'd1);
    send_cmd(CMD_INSERT, 9'd0, 32'd1);
    drain_results();
    write_capacity(9'd4);
    repeat (4) send_cmd(CMD_INSERT, IDX_W'(shadow_len), pick_value(20));
    drain_results();
    write_capacity(9'd2);
    send_cmd(CMD_INSERT, 9'd1, 32'd3);
    send_cmd(CMD_READ, 9'd3, 32'd0);
    send_cmd(CMD_SEARCH, 9'd0, shadow_words[2]);
    send_cmd(CMD_DELETE, 9'd0, 32'd0);
  endtask

  task automatic test_full_depth();
    drain_results();
    write_capacity(9'h1FF);
    trim_list(0);
    while (shadow_len < LIST_DEPTH - 1)
      send_cmd(CMD_INSERT, IDX_W'(shadow_len),
               shadow_len * 64 - 20000 + $urandom_range(0, 63));
    send_cmd(CMD_SORTED, pick_index(511), 32'h7FFF_FFFF);
    send_cmd(CMD_INSERT, 9'd256, 32'd5);
    send_cmd(CMD_INSERT, 9'd257, 32'd5);
    send_cmd(CMD_SORTED, 9'd0, 32'd0);
    send_cmd(CMD_SEARCH, 9'd0, 32'h7FFF_FFFF);
    send_cmd(CMD_SEARCH, 9'd0, 32'h8000_0001);
    send_cmd(CMD_READ, 9'd255, 32'd0);
    send_cmd(CMD_DELETE, 9'd255, 32'd0);
    drain_results();
    write_capacity(CAP_RESET);
    send_cmd(CMD_INSERT, 9'd0, 32'h8000_0000);
    send_cmd(CMD_INSERT, 9'd100, 32'd1);
    trim_list(8);
  endtask

  task automatic test_random_traffic(int unsigned total);
    logic [CAP_W-1:0] caps [10];
    int unsigned first;
    int unsigned phase;
    int unsigned len;
    caps = '{9'd5, 9'd64, 9'd1, 9'd0, 9'd40, 9'h1FF, 9'd12, 9'd256, 9'd2, 9'd100};
    first = items_sent;
    phase = 0;
    while (items_sent - first < total) begin
      drain_results();
      write_capacity(caps[phase % 10]);
      idle_pct = (phase == 5) ? 0 : 18;
      len = $urandom_range(60, 180);
      if (phase % 3 == 1) sorted_session(len);
      else repeat (len) random_mixed_item();
      phase++;
    end
    idle_pct = 18;
  endtask

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_failure($sformatf("unexpected result status %0d data %h position %0d count %0d",
                                 out_status, out_data, out_position, out_count));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_data !== want.data ||
            out_position !== want.position || out_count !== want.count) begin
          report_failure($sformatf({"cmd %0d index %0d: expected status %0d data %h ",
                                    "position %0d count %0d, got status %0d data %h ",
                                    "position %0d count %0d"},
                                   want.cmd, want.index, want.status, want.data,
                                   want.position, want.count, out_status, out_data,
                                   out_position, out_count));
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_basics();
    test_capacity_limits();
    test_full_depth();
    test_random_traffic(RANDOM_ITEMS);
    drain_results();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0)
      report_failure($sformatf("%0d results never arrived", pending_results.size()));
    $display("Ran %0d commands: insert %0d, delete %0d, read %0d, write %0d, search %0d, %s",
             items_sent, cmd_tally[CMD_INSERT], cmd_tally[CMD_DELETE], cmd_tally[CMD_READ],
             cmd_tally[CMD_WRITE], cmd_tally[CMD_SEARCH],
             $sformatf("sorted %0d, unused codes %0d", cmd_tally[CMD_SORTED],
                       cmd_tally[CMD_SPARE_A] + cmd_tally[CMD_SPARE_B]));
    $display("Checked %0d results (ok %0d, range %0d, full %0d, miss %0d, unsorted %0d); %s",
             results_seen, status_tally[ST_OK], status_tally[ST_RANGE], status_tally[ST_FULL],
             status_tally[ST_NOT_FOUND], status_tally[ST_UNSORTED],
             $sformatf("%0d capacity writes, longest list %0d, %0d mismatches",
                       cap_writes, longest_list, mismatches));
    if (mismatches == 0) begin
      $display("[indexed_array_list_top] OK");
    end else begin
      $display("[indexed_array_list_top] ERROR");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("[indexed_array_list_top] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
src/ial_pkg.sv
src/ial_cell.sv
src/ial_chain.sv
src/ial_ctrl.sv
src/indexed_array_list_top.sv
tb/tb_top.sv
